FILE: rtl/itp_pkg.sv
// Shared types, character constants and operator tables for the infix to postfix converter.
package itp_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_MUL   = 8'h2a;
   localparam logic [7:0] CHAR_ADD   = 8'h2b;
   localparam logic [7:0] CHAR_SUB   = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_DIV   = 8'h2f;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POW   = 8'h5e;
   localparam logic [7:0] CHAR_NULL  = 8'h00;

   typedef enum logic [2:0] {
      CODE_ADD  = 3'd0,
      CODE_SUB  = 3'd1,
      CODE_MUL  = 3'd2,
      CODE_DIV  = 3'd3,
      CODE_POW  = 3'd4,
      CODE_OPEN = 3'd5
   } code_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNMATCHED = 2'd1,
      ERR_FULL      = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD,
      ST_DISPATCH,
      ST_POP_OP,
      ST_SPACE,
      ST_POP_PAR,
      ST_FIN
   } st_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      code_type code;
   } stack_ctl_type;

   function automatic logic is_op_char(input logic [7:0] ch);
      return (ch == CHAR_ADD) || (ch == CHAR_SUB) || (ch == CHAR_MUL) ||
             (ch == CHAR_DIV) || (ch == CHAR_POW);
   endfunction

   function automatic code_type op_code_of(input logic [7:0] ch);
      code_type c;
      c = CODE_ADD;
      if (ch == CHAR_SUB) c = CODE_SUB;
      if (ch == CHAR_MUL) c = CODE_MUL;
      if (ch == CHAR_DIV) c = CODE_DIV;
      if (ch == CHAR_POW) c = CODE_POW;
      return c;
   endfunction

   function automatic logic [7:0] code_char(input code_type c);
      logic [7:0] ch;
      unique case (c)
         CODE_ADD:  ch = CHAR_ADD;
         CODE_SUB:  ch = CHAR_SUB;
         CODE_MUL:  ch = CHAR_MUL;
         CODE_DIV:  ch = CHAR_DIV;
         CODE_POW:  ch = CHAR_POW;
         CODE_OPEN: ch = CHAR_OPEN;
         default:   ch = CHAR_ADD;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] code_prec(input code_type c);
      logic [1:0] p;
      unique case (c)
         CODE_ADD, CODE_SUB: p = 2'd1;
         CODE_MUL, CODE_DIV: p = 2'd2;
         CODE_POW:           p = 2'd3;
         CODE_OPEN:          p = 2'd0;
         default:            p = 2'd1;
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/itp_stack_cell.sv
// One cell of the operator stack chain: holds one code and shifts with its neighbors.
module itp_stack_cell import itp_pkg::*; (
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  code_type      up_code,
   input  code_type      down_code,
   output code_type      code
);

   code_type code_ff;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         code_ff <= up_code;
      end else if (ctl.pop) begin
         code_ff <= down_code;
      end
   end

   assign code = code_ff;

endmodule

FILE: rtl/itp_control.sv
// Sequencer for the converter: parses characters, drives the stack chain and the result registers.
module itp_control import itp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_char_in,
   input  logic          req_final_char,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_char_out,
   output logic          rsp_end_of_output,
   output logic [1:0]    rsp_error_code,
   output stack_ctl_type stack_ctl,
   input  code_type      top_code
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

   st_type           state_ff, state_in;
   st_type           ret_ff, ret_in;
   logic [7:0]       char_ff;
   logic             fin_ff;
   logic             inside_ff;
   logic [CNT_W-1:0] count_ff;
   logic             hold_valid_ff;
   logic [7:0]       hold_char_ff;
   err_type          hold_err_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_end_ff;
   err_type          rsp_err_ff;

   logic       is_digit, is_dot, is_op, is_open, is_close;
   logic       empty, full, top_open, pop_op_cond;
   logic       out_free, emit_ok, go;
   logic       want_emit, push_w, pop_w, set_w, clr_w, finish_w, need_out;
   logic       emit, push, pop, finish;
   logic [7:0] emit_char;
   err_type    emit_err;
   code_type   push_code;

   assign is_digit = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign is_dot   = (char_ff == CHAR_DOT);
   assign is_op    = is_op_char(char_ff);
   assign is_open  = (char_ff == CHAR_OPEN);
   assign is_close = (char_ff == CHAR_CLOSE);

   assign empty       = (count_ff == '0);
   assign full        = (count_ff == FULL_COUNT);
   assign top_open    = (top_code == CODE_OPEN);
   assign pop_op_cond = !empty && !top_open &&
                        (code_prec(top_code) >= code_prec(op_code_of(char_ff)));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_ok  = !hold_valid_ff || out_free;

   always_comb begin
      want_emit = 1'b0;
      emit_char = CHAR_NULL;
      emit_err  = ERR_NONE;
      push_w    = 1'b0;
      push_code = CODE_ADD;
      pop_w     = 1'b0;
      set_w     = 1'b0;
      clr_w     = 1'b0;
      finish_w  = 1'b0;
      need_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LEAD: begin
            if (inside_ff) begin
               want_emit = 1'b1;
               if (is_digit || is_dot) begin
                  emit_char = char_ff;
               end else begin
                  emit_char = CHAR_SPACE;
                  clr_w     = 1'b1;
               end
            end
         end
         ST_DISPATCH: begin
            if (is_digit) begin
               want_emit = 1'b1;
               emit_char = char_ff;
               set_w     = 1'b1;
            end else if (is_open) begin
               if (full) begin
                  want_emit = 1'b1;
                  emit_err  = ERR_FULL;
               end else begin
                  push_w    = 1'b1;
                  push_code = CODE_OPEN;
               end
            end
         end
         ST_POP_OP: begin
            priority if (pop_op_cond) begin
               want_emit = 1'b1;
               emit_char = code_char(top_code);
               pop_w     = 1'b1;
            end else if (full) begin
               want_emit = 1'b1;
               emit_err  = ERR_FULL;
            end else begin
               push_w    = 1'b1;
               push_code = op_code_of(char_ff);
            end
         end
         ST_SPACE: begin
            want_emit = 1'b1;
            emit_char = CHAR_SPACE;
         end
         ST_POP_PAR: begin
            priority if (!empty && !top_open) begin
               want_emit = 1'b1;
               emit_char = code_char(top_code);
               pop_w     = 1'b1;
            end else if (!empty) begin
               pop_w = 1'b1;
            end else begin
               want_emit = 1'b1;
               emit_err  = ERR_UNMATCHED;
            end
         end
         ST_FIN: begin
            priority if (fin_ff && inside_ff) begin
               want_emit = 1'b1;
               emit_char = CHAR_SPACE;
               clr_w     = 1'b1;
            end else if (fin_ff && !empty) begin
               want_emit = 1'b1;
               emit_char = code_char(top_code);
               pop_w     = 1'b1;
            end else begin
               finish_w = 1'b1;
               need_out = hold_valid_ff || fin_ff;
            end
         end
         default: begin
         end
      endcase
      go     = want_emit ? emit_ok : (need_out ? out_free : 1'b1);
      emit   = want_emit && go;
      push   = push_w && go;
      pop    = pop_w && go;
      finish = finish_w && go;
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LEAD;
         end
         ST_LEAD: begin
            if (go) state_in = (inside_ff && (is_digit || is_dot)) ? ST_FIN : ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (go) begin
               priority if (is_digit) state_in = ST_FIN;
               else if (is_op) state_in = ST_POP_OP;
               else if (is_close) state_in = ST_POP_PAR;
               else state_in = ST_FIN;
            end
         end
         ST_POP_OP: begin
            if (go) begin
               if (pop_op_cond) begin
                  state_in = ST_SPACE;
                  ret_in   = ST_POP_OP;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SPACE: begin
            if (go) state_in = ret_ff;
         end
         ST_POP_PAR: begin
            if (go) begin
               if (!empty && !top_open) begin
                  state_in = ST_SPACE;
                  ret_in   = ST_POP_PAR;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (go) begin
               priority if (fin_ff && inside_ff) begin
                  state_in = ST_FIN;
               end else if (fin_ff && !empty) begin
                  state_in = ST_SPACE;
                  ret_in   = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         char_ff <= req_char_in;
         fin_ff  <= req_final_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (set_w && go) begin
            inside_ff <= 1'b1;
         end else if (clr_w && go) begin
            inside_ff <= 1'b0;
         end
         if (push) begin
            count_ff <= count_ff + ONE_COUNT;
         end else if (pop) begin
            count_ff <= count_ff - ONE_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            hold_valid_ff <= 1'b1;
            hold_char_ff  <= emit_char;
            hold_err_ff   <= emit_err;
            if (hold_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= hold_char_ff;
               rsp_err_ff   <= hold_err_ff;
               rsp_end_ff   <= 1'b0;
            end else if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (finish && hold_valid_ff) begin
            hold_valid_ff <= 1'b0;
            rsp_valid_ff  <= 1'b1;
            rsp_char_ff   <= hold_char_ff;
            rsp_err_ff    <= hold_err_ff;
            rsp_end_ff    <= fin_ff;
         end else if (finish && fin_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_char_ff  <= CHAR_NULL;
            rsp_err_ff   <= ERR_NONE;
            rsp_end_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_end_of_output = rsp_end_ff;
   assign rsp_error_code    = rsp_err_ff;

   assign stack_ctl.push = push;
   assign stack_ctl.pop  = pop;
   assign stack_ctl.code = push_code;

endmodule

FILE: rtl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: sequencer plus the operator stack chain.
//
// The converter takes an infix expression one ASCII character per transaction and returns
// the postfix form one character per transaction, with a space after each number and each
// operator. A character is handled by the sequencer in itp_control one step per clock, and
// a stalled result holds the sequencer until it is taken. Every operator taken off the
// stack is given in one step and its space in the next, and a number still open at the
// final character is closed with a space. The operator stack is a chain of STACK_DEPTH
// cells that all shift by one place on a push or a pop, so the top entry is always in the
// first cell. An unmatched close parenthesis gives a result with error code 1 and a push
// onto a full stack gives error code 2, both with character 0. The last result caused by
// the final character carries end_of_output, and a final character that causes nothing
// gives a single result with character 0.
module infix_to_postfix_converter import itp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_final_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_end_of_output,
   output logic [1:0] rsp_error_code
);

   stack_ctl_type stack_ctl;
   code_type      cell_code [STACK_DEPTH];

   itp_control #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_control (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_final_char    (req_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_end_of_output (rsp_end_of_output),
      .rsp_error_code    (rsp_error_code),
      .stack_ctl         (stack_ctl),
      .top_code          (cell_code[0])
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      code_type up_code;
      code_type down_code;

      if (i == 0) begin : g_first
         assign up_code = stack_ctl.code;
      end else begin : g_inner_up
         assign up_code = cell_code[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_code = CODE_ADD;
      end else begin : g_inner_down
         assign down_code = cell_code[i+1];
      end

      itp_stack_cell u_cell (
         .clock     (clock),
         .ctl       (stack_ctl),
         .up_code   (up_code),
         .down_code (down_code),
         .code      (cell_code[i])
      );
   end

endmodule

FILE: tb/sv/tb_infix_to_postfix_converter.sv
// Testbench for the infix to postfix converter: directed and random expressions with a predictor.
module tb_infix_to_postfix_converter import itp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_CHARS = 125;
   localparam int MAX_REPORTS = 40;
   localparam logic [1:0] PREC_OF [0:5] = '{2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};
   localparam logic [7:0] CHAR_OF [0:5] =
      '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV, CHAR_POW, CHAR_OPEN};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      err_type    err;
   } postfix_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_final_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_end_of_output;
   logic [1:0] rsp_error_code;

   code_type         op_stack [STACK_DEPTH];
   int               op_depth = 0;
   logic             in_number = 1'b0;
   postfix_char_type new_chars [$];
   postfix_char_type pending_postfix [$];
   postfix_char_type oldest;
   byte unsigned     expr_text [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int fail_count = 0;
   int chars_sent = 0;
   int expressions_sent = 0;
   int results_checked = 0;
   int error_results = 0;
   int cycle_count = 0;

   infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_final_char    (req_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_end_of_output (rsp_end_of_output),
      .rsp_error_code    (rsp_error_code)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("infix_to_postfix_converter: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic void add_result(input logic [7:0] ch, input err_type err);
      postfix_char_type r;
      r.ch = ch;
      r.last = 1'b0;
      r.err = err;
      new_chars = {new_chars, r};
   endfunction

   function automatic void pop_to_output();
      op_depth--;
      add_result(CHAR_OF[op_stack[op_depth]], ERR_NONE);
      add_result(CHAR_SPACE, ERR_NONE);
   endfunction

   function automatic void push_code(input code_type c);
      if (op_depth >= STACK_DEPTH) begin
         add_result(CHAR_NULL, ERR_FULL);
      end else begin
         op_stack[op_depth] = c;
         op_depth++;
      end
   endfunction

   function automatic void predict_postfix(input logic [7:0] ch, input logic fin);
      logic     digit;
      logic     is_op;
      logic     number_kept;
      code_type op;
      new_chars.delete();
      digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      number_kept = 1'b0;
      if (in_number) begin
         if (digit || ch == CHAR_DOT) begin
            add_result(ch, ERR_NONE);
            number_kept = 1'b1;
         end else begin
            add_result(CHAR_SPACE, ERR_NONE);
            in_number = 1'b0;
         end
      end
      if (!number_kept) begin
         is_op = 1'b1;
         op = CODE_ADD;
         case (ch)
            CHAR_ADD: op = CODE_ADD;
            CHAR_SUB: op = CODE_SUB;
            CHAR_MUL: op = CODE_MUL;
            CHAR_DIV: op = CODE_DIV;
            CHAR_POW: op = CODE_POW;
            default:  is_op = 1'b0;
         endcase
         if (digit) begin
            add_result(ch, ERR_NONE);
            in_number = 1'b1;
         end else if (is_op) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CODE_OPEN &&
                   PREC_OF[op_stack[op_depth - 1]] >= PREC_OF[op])
               pop_to_output();
            push_code(op);
         end else if (ch == CHAR_OPEN) begin
            push_code(CODE_OPEN);
         end else if (ch == CHAR_CLOSE) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CODE_OPEN)
               pop_to_output();
            if (op_depth > 0) op_depth--;
            else add_result(CHAR_NULL, ERR_UNMATCHED);
         end
      end
      if (fin) begin
         if (in_number) begin
            add_result(CHAR_SPACE, ERR_NONE);
            in_number = 1'b0;
         end
         while (op_depth > 0)
            pop_to_output();
         if (new_chars.size() == 0) add_result(CHAR_NULL, ERR_NONE);
         new_chars[new_chars.size() - 1].last = 1'b1;
      end
      foreach (new_chars[i]) pending_postfix = {pending_postfix, new_chars[i]};
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $error("%s: expected %0h, got %0h", field, want, got);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (rsp_error_code != ERR_NONE) error_results++;
         if (pending_postfix.size() == 0) begin
            note_mismatch("unexpected transaction, char_out", -1, rsp_char_out);
         end else begin
            oldest = pending_postfix.pop_front();
            if (rsp_char_out !== oldest.ch)
               note_mismatch("char_out", oldest.ch, rsp_char_out);
            if (rsp_end_of_output !== oldest.last)
               note_mismatch("end_of_output", oldest.last, rsp_end_of_output);
            if (rsp_error_code !== oldest.err)
               note_mismatch("error_code", oldest.err, rsp_error_code);
         end
      end
   end

   function automatic void add_text_char(input byte unsigned c);
      expr_text = {expr_text, c};
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= ch;
      req_final_char <= fin;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_postfix(ch, fin);
      chars_sent++;
   endtask

   task automatic send_text();
      foreach (expr_text[i]) send_char(expr_text[i], i == expr_text.size() - 1);
      expressions_sent++;
   endtask

   task automatic send_string(input string s);
      expr_text.delete();
      for (int i = 0; i < s.len(); i++) add_text_char(s[i]);
      send_text();
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_postfix.size() != 0) @(posedge clock);
   endtask

   function automatic void add_number();
      int digits;
      digits = $urandom_range(1, 3);
      repeat (digits) add_text_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
         add_text_char(CHAR_DOT);
         digits = $urandom_range(0, 2);
         repeat (digits) add_text_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic byte unsigned random_operator();
      byte unsigned ops [5];
      ops = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV, CHAR_POW};
      return ops[$urandom_range(0, 4)];
   endfunction

   task automatic send_random_expression();
      string tokens;
      int    kind;
      int    operands;
      int    opens;
      int    n;
      tokens = "0123456789.+-*/^()() x";
      kind = $urandom_range(0, 99);
      expr_text.delete();
      if (kind < 70) begin
         operands = $urandom_range(1, 6);
         opens = 0;
         for (int i = 0; i < operands; i++) begin
            if (i > 0) add_text_char(random_operator());
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n) add_text_char(CHAR_OPEN);
            opens += n;
            add_number();
            if (opens > 0 && $urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, opens);
               repeat (n) add_text_char(CHAR_CLOSE);
               opens -= n;
            end
            if ($urandom_range(0, 9) == 0) add_text_char(CHAR_SPACE);
         end
         if ($urandom_range(0, 4) != 0)
            repeat (opens) add_text_char(CHAR_CLOSE);
      end else if (kind < 80) begin
         n = $urandom_range(12, STACK_DEPTH + 2);
         repeat (n) add_text_char(($urandom_range(0, 3) == 0) ? random_operator() : CHAR_OPEN);
         add_number();
         n = $urandom_range(0, n);
         repeat (n) add_text_char(CHAR_CLOSE);
      end else if (kind < 90) begin
         n = $urandom_range(1, 12);
         repeat (n) add_text_char(tokens[$urandom_range(0, tokens.len() - 1)]);
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) add_text_char(8'($urandom_range(0, 255)));
      end
      send_text();
   endtask

   task automatic test_numbers();
      send_string("90.5.x");
      send_string(".7");
   endtask

   task automatic test_operators();
      send_string("1+2*3^4^5/6-7");
      send_char(8'hff, 1'b0);
      send_char(CHAR_NULL, 1'b1);
      expressions_sent++;
   endtask

   task automatic test_parentheses();
      send_string("(1+2))");
      send_string("((");
   endtask

   task automatic test_full_stack();
      expr_text.delete();
      repeat (STACK_DEPTH + 1) add_text_char(CHAR_OPEN);
      add_text_char(8'(CHAR_ZERO + 1));
      send_text();
      wait_drain();
   endtask

   task automatic test_random();
      int phase_goal;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               hold_left = HOLD_OFF_CYCLES;
            end
            1: begin
               send_idle_pct = 68;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 68;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
            end
         endcase
         phase_goal = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_goal) send_random_expression();
         wait_drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_numbers();
      test_operators();
      test_parentheses();
      test_full_stack();
      test_random();
      wait_drain();
      repeat (40) @(posedge clock);
      $display(
         "Converted %0d expressions (%0d characters) under four idling mixes and a hold-off.",
         expressions_sent, chars_sent);
      $display("Checked %0d postfix transactions, %0d of them error results.",
               results_checked, error_results);
      if (fail_count == 0) begin
         $display("infix_to_postfix_converter: match");
      end else begin
         $display("infix_to_postfix_converter: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/itp_pkg.sv
rtl/itp_stack_cell.sv
rtl/itp_control.sv
rtl/infix_to_postfix_converter.sv
tb/sv/tb_infix_to_postfix_converter.sv
